FILE: rtl/core/gsno_pkg.sv
// Shared constants, types and the semitone table of the gated sine note oscillator.
package gsno_pkg;

    localparam int PHASE_BITS      = 32;
    localparam int SINE_TABLE_BITS = 10;
    localparam int SAMPLE_BITS     = 16;

    localparam int OPCODE_BITS    = 2;
    localparam int NOTE_BITS      = 7;
    localparam int PITCH_BITS     = 16;
    localparam int VOL_BITS       = 16;
    localparam int SR_BITS        = 18;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 18;

    localparam logic [OPCODE_BITS-1:0] OP_TICK     = 2'd0;
    localparam logic [OPCODE_BITS-1:0] OP_NOTE_ON  = 2'd1;
    localparam logic [OPCODE_BITS-1:0] OP_NOTE_OFF = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_PITCH  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_VOLUME = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATE   = 2'd2;

    localparam logic [PITCH_BITS-1:0] PITCH_RESET  = 16'd32768;
    localparam logic [VOL_BITS-1:0]   VOLUME_RESET = 16'd32768;
    localparam logic [SR_BITS-1:0]    RATE_RESET   = 18'd48000;

    // pitch word: note*8192 + 3*offset, 1/8192 semitone steps
    localparam int FRAC_BITS = 13;
    localparam int V_BITS    = 21;
    localparam int S_BITS    = V_BITS - FRAC_BITS;
    localparam int OCT_BITS  = 4;
    localparam int K_BITS    = 4;

    localparam logic [S_BITS-1:0] SEMIS_PER_OCT = 8'd12;
    localparam logic [7:0]        DIV12_RECIP   = 8'd171;
    localparam int                DIV12_SHIFT   = 11;

    localparam int TBL_BITS   = 28;
    localparam int DIFF_BITS  = 23;
    localparam int FREQ_BITS  = 32;
    localparam int FREQ_DROP  = 8;
    localparam int SHIFT_BITS = FREQ_BITS + FREQ_DROP;

    localparam int DIV_BITS     = FREQ_BITS + PHASE_BITS - 16;
    localparam int DIV_CNT_BITS = $clog2(DIV_BITS);

    localparam int MUL_A_BITS = 23;
    localparam int MUL_B_BITS = 16;
    localparam int MUL_P_BITS = MUL_A_BITS + MUL_B_BITS;

    localparam int Q_SHIFT = 15;
    localparam int Z_BITS  = 16;
    localparam int X_BITS  = SINE_TABLE_BITS - 2;
    localparam int Z_SHIFT = 17 - SINE_TABLE_BITS;

    localparam logic [Z_BITS-1:0]     Z_QUARTER = 16'd32768;
    localparam logic [MUL_B_BITS-1:0] C_T2      = 16'd2320;
    localparam logic [14:0]           C_T       = 15'd21024;
    localparam logic [Z_BITS-1:0]     C_U       = 16'd51472;
    localparam logic [14:0]           SINE_MAX  = 15'd32767;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_OCT,
        ST_SEMI,
        ST_INTERP,
        ST_FREQ,
        ST_DIV,
        ST_Z2,
        ST_T,
        ST_U,
        ST_S,
        ST_MAG,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic                  en;
        logic [MUL_A_BITS-1:0] a;
        logic [MUL_B_BITS-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                start;
        logic [DIV_BITS-1:0] dividend;
        logic [SR_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [PHASE_BITS-1:0] quotient;
    } div_rsp_t;

    // frequency of note k-12 in Q4.24
    function automatic logic [TBL_BITS-1:0] semitone_freq(input logic [K_BITS-1:0] k);
        logic [TBL_BITS-1:0] f;
        case (k)
            4'd0:    f = 28'd68583572;
            4'd1:    f = 28'd72661763;
            4'd2:    f = 28'd76982457;
            4'd3:    f = 28'd81560072;
            4'd4:    f = 28'd86409886;
            4'd5:    f = 28'd91548085;
            4'd6:    f = 28'd96991818;
            4'd7:    f = 28'd102759251;
            4'd8:    f = 28'd108869634;
            4'd9:    f = 28'd115343360;
            4'd10:   f = 28'd122202033;
            4'd11:   f = 28'd129468544;
            4'd12:   f = 28'd137167144;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

FILE: rtl/core/gsno_if.sv
// Valid/ready channel interfaces for note commands and audio samples.
interface gsno_cmd_if;
    import gsno_pkg::*;

    logic                   valid;
    logic                   ready;
    logic [OPCODE_BITS-1:0] opcode;
    logic [NOTE_BITS-1:0]   note_number;

    modport source (output valid, output opcode, output note_number, input ready);
    modport sink   (input valid, input opcode, input note_number, output ready);
endinterface

interface gsno_audio_if;
    import gsno_pkg::*;

    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] sample;

    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

FILE: rtl/core/gsno_mul.sv
// Shared unsigned multiplier with registered product.
module gsno_mul (
    input  logic                                clk,
    input  gsno_pkg::mul_req_t                  req,
    output logic [gsno_pkg::MUL_P_BITS-1:0]     prod
);
    import gsno_pkg::*;

    logic [MUL_P_BITS-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        if (req.en)
        begin
            prod_reg <= MUL_P_BITS'(req.a) * MUL_P_BITS'(req.b);
        end
    end

    assign prod = prod_reg;

endmodule

FILE: rtl/core/gsno_div.sv
// Restoring divider, one quotient bit per cycle, quotient kept modulo the phase width.
module gsno_div (
    input  logic               clk,
    input  logic               rst_n,
    input  gsno_pkg::div_req_t req,
    output gsno_pkg::div_rsp_t rsp
);
    import gsno_pkg::*;

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [DIV_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic [DIV_BITS-1:0]     dvd_reg, dvd_next;
    logic [SR_BITS-1:0]      dsr_reg, dsr_next;
    logic [SR_BITS-1:0]      rem_reg, rem_next;
    logic [PHASE_BITS-1:0]   quo_reg, quo_next;

    logic [SR_BITS:0] trial;
    logic             ge;

    assign trial = {rem_reg, dvd_reg[DIV_BITS-1]};
    assign ge    = trial >= {1'b0, dsr_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
            rem_next  = '0;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            dvd_next = dvd_reg << 1;
            rem_next = ge ? SR_BITS'(trial - {1'b0, dsr_reg}) : trial[SR_BITS-1:0];
            quo_next = {quo_reg[PHASE_BITS-2:0], ge};
            cnt_next = DIV_CNT_BITS'(cnt_reg + 1'b1);
            if (cnt_reg == DIV_CNT_BITS'(DIV_BITS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = quo_reg;

endmodule

FILE: rtl/core/gated_sine_note_oscillator_top.sv
// Top level of the gated sine note oscillator: sequencer, state and config registers.
//
//   port       dir   handshake      payload
//   cmd        in    valid/ready    opcode[1:0], note_number[6:0]
//   audio      out   valid/ready    sample[15:0] signed Q1.15
//   cfg_*      in    cfg_we only    cfg_index[1:0], cfg_data[17:0]
//
// Note on/off and ignored opcodes leave the sequencer idle; a tick runs from transfer to
// ready through four setup steps, the 48-step restoring divider, five multiplier steps
// (skipped with the gate closed) and one output step; seven multiplier passes, or two with the gate closed.
// A zero sample rate makes a tick a no-op.
// After reset the block is idle with the gate closed and phase zero.
// A stalled sample holds the sequencer in its last step until the output slot frees.
module gated_sine_note_oscillator_top (
    input  logic                                clk,
    input  logic                                rst_n,
    gsno_cmd_if.sink                            cmd,
    gsno_audio_if.source                        audio,
    input  logic                                cfg_we,
    input  logic [gsno_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [gsno_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import gsno_pkg::*;

    state_t state_reg, state_next;

    logic [PITCH_BITS-1:0] pitch_reg;
    logic [VOL_BITS-1:0]   volume_reg;
    logic [SR_BITS-1:0]    rate_reg;

    logic [PHASE_BITS-1:0]  phase_reg;
    logic [NOTE_BITS-1:0]   held_note_reg;
    logic                   gate_reg;
    logic                   out_valid_reg;
    logic [SAMPLE_BITS-1:0] sample_reg;

    logic [V_BITS-1:0]   v_reg;
    logic [OCT_BITS-1:0] oct_reg;
    logic [K_BITS-1:0]   k_reg;
    logic [Z_BITS-1:0]   z2_reg;

    mul_req_t              mul_req;
    logic [MUL_P_BITS-1:0] mul_prod;
    div_req_t              div_req;
    div_rsp_t              div_rsp;

    logic cmd_xfer;
    logic emit;

    logic [V_BITS-1:0]      v_now;
    logic [S_BITS-1:0]      s_val;
    logic [OCT_BITS-1:0]    oct_now;
    logic [K_BITS-1:0]      k_now;
    logic [DIFF_BITS-1:0]   diff;
    logic [TBL_BITS-1:0]    base;
    logic [SHIFT_BITS-1:0]  shifted;
    logic [FREQ_BITS-1:0]   fr;
    logic [SINE_TABLE_BITS-1:0] idx;
    logic [X_BITS-1:0]      x_val;
    logic [Z_BITS-1:0]      z_base;
    logic [Z_BITS-1:0]      z_val;
    logic [Z_BITS-1:0]      z2_now;
    logic [14:0]            t_val;
    logic [Z_BITS-1:0]      u_val;
    logic [Z_BITS-1:0]      s_raw;
    logic [14:0]            s_sat;
    logic [SAMPLE_BITS-1:0] mag;
    logic [SAMPLE_BITS-1:0] sample_now;

    gsno_mul u_mul (
        .clk  (clk),
        .req  (mul_req),
        .prod (mul_prod)
    );

    gsno_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // datapath
    assign v_now   = (V_BITS'(held_note_reg) << FRAC_BITS) + (V_BITS'(pitch_reg) << 1)
                   + V_BITS'(pitch_reg);
    assign s_val   = v_reg[V_BITS-1:FRAC_BITS];
    assign oct_now = OCT_BITS'(mul_prod >> DIV12_SHIFT);
    assign k_now   = K_BITS'(s_val - S_BITS'(oct_now) * SEMIS_PER_OCT);
    assign diff    = DIFF_BITS'(semitone_freq(K_BITS'(k_reg + 1'b1)) - semitone_freq(k_reg));
    assign base    = TBL_BITS'(semitone_freq(k_reg) + TBL_BITS'(mul_prod >> FRAC_BITS));
    assign shifted = SHIFT_BITS'(base) << oct_reg;
    assign fr      = shifted[SHIFT_BITS-1 -: FREQ_BITS];

    assign idx    = phase_reg[PHASE_BITS-1 -: SINE_TABLE_BITS];
    assign x_val  = idx[X_BITS-1:0];
    assign z_base = Z_BITS'(x_val) << Z_SHIFT;
    assign z_val  = idx[X_BITS] ? Z_BITS'(Z_QUARTER - z_base) : z_base;

    assign z2_now = Z_BITS'(mul_prod >> Q_SHIFT);
    assign t_val  = 15'(C_T - 15'(mul_prod >> Q_SHIFT));
    assign u_val  = Z_BITS'(C_U - Z_BITS'(mul_prod >> Q_SHIFT));
    assign s_raw  = Z_BITS'(mul_prod >> Q_SHIFT);
    assign s_sat  = (s_raw > Z_BITS'(SINE_MAX)) ? SINE_MAX : s_raw[14:0];

    assign mag        = SAMPLE_BITS'(mul_prod >> (32 - SAMPLE_BITS));
    assign sample_now = !gate_reg ? '0
                      : (idx[SINE_TABLE_BITS-1] ? SAMPLE_BITS'(SAMPLE_BITS'(0) - mag) : mag);

    assign cmd_xfer = cmd.valid && cmd.ready;
    assign emit     = (state_reg == ST_EMIT) && (!out_valid_reg || audio.ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_xfer && cmd.opcode == OP_TICK && rate_reg != '0)
                begin
                    state_next = ST_OCT;
                end
            end
            ST_OCT:    state_next = ST_SEMI;
            ST_SEMI:   state_next = ST_INTERP;
            ST_INTERP: state_next = ST_FREQ;
            ST_FREQ:   state_next = ST_DIV;
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    state_next = gate_reg ? ST_Z2 : ST_EMIT;
                end
            end
            ST_Z2:     state_next = ST_T;
            ST_T:      state_next = ST_U;
            ST_U:      state_next = ST_S;
            ST_S:      state_next = ST_MAG;
            ST_MAG:    state_next = ST_EMIT;
            ST_EMIT:
            begin
                if (emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    // unit requests
    always_comb
    begin
        mul_req          = '0;
        div_req.start    = 1'b0;
        div_req.dividend = DIV_BITS'(fr) << (PHASE_BITS - 16);
        div_req.divisor  = rate_reg;
        unique case (state_reg)
            ST_OCT:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(s_val);
                mul_req.b  = MUL_B_BITS'(DIV12_RECIP);
            end
            ST_INTERP:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(diff);
                mul_req.b  = MUL_B_BITS'(v_reg[FRAC_BITS-1:0]);
            end
            ST_FREQ:
            begin
                div_req.start = 1'b1;
            end
            ST_Z2:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(z_val);
                mul_req.b  = z_val;
            end
            ST_T:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(z2_now);
                mul_req.b  = C_T2;
            end
            ST_U:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(z2_reg);
                mul_req.b  = MUL_B_BITS'(t_val);
            end
            ST_S:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(z_val);
                mul_req.b  = u_val;
            end
            ST_MAG:
            begin
                mul_req.en = 1'b1;
                mul_req.a  = MUL_A_BITS'(s_sat);
                mul_req.b  = volume_reg;
            end
            default:
            begin
                mul_req = '0;
            end
        endcase
    end

    assign cmd.ready    = (state_reg == ST_IDLE);
    assign audio.valid  = out_valid_reg;
    assign audio.sample = sample_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pitch_reg  <= PITCH_RESET;
            volume_reg <= VOLUME_RESET;
            rate_reg   <= RATE_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_PITCH:  pitch_reg  <= cfg_data[PITCH_BITS-1:0];
                CFG_VOLUME: volume_reg <= cfg_data[VOL_BITS-1:0];
                CFG_RATE:   rate_reg   <= cfg_data[SR_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= '0;
            held_note_reg <= '0;
            gate_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cmd_xfer)
            begin
                unique case (cmd.opcode)
                    OP_NOTE_ON:
                    begin
                        held_note_reg <= cmd.note_number;
                        gate_reg      <= 1'b1;
                    end
                    OP_NOTE_OFF:
                    begin
                        gate_reg <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (state_reg == ST_DIV && div_rsp.done)
            begin
                phase_reg <= PHASE_BITS'(phase_reg + div_rsp.quotient);
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (audio.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd_xfer)
        begin
            v_reg <= v_now;
        end
        if (state_reg == ST_SEMI)
        begin
            oct_reg <= oct_now;
            k_reg   <= k_now;
        end
        if (state_reg == ST_T)
        begin
            z2_reg <= z2_now;
        end
        if (emit)
        begin
            sample_reg <= sample_now;
        end
    end

`ifndef NO_ASSERTIONS
    a_div_leaves: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV && div_rsp.done) |=> (state_reg != ST_DIV))
        else $error("sequencer stayed in divide after quotient");

    a_phase_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(state_reg == ST_DIV && div_rsp.done) |=> $stable(phase_reg))
        else $error("phase changed outside a tick update");

    a_emit_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && out_valid_reg && !audio.ready) |=> (state_reg == ST_EMIT))
        else $error("sample emitted over an untaken one");

    a_zero_rate: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_xfer && cmd.opcode == OP_TICK && rate_reg == '0) |=> (state_reg == ST_IDLE))
        else $error("tick with zero rate started work");

    a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (out_valid_reg && sample_reg == $past(sample_now)))
        else $error("emitted sample not presented");
`endif

endmodule

FILE: bench/sine_sample_scoreboard_pkg.sv
// Oscillator bench scoreboard class: predicts samples of nonzero-rate ticks, checks the audio stream.
package sine_sample_scoreboard_pkg;
    import gsno_pkg::*;

    localparam logic [OPCODE_BITS-1:0] OP_UNUSED = 2'd3;

    class sine_sample_scoreboard;
        logic [PITCH_BITS-1:0]         pitch_offset;
        logic [VOL_BITS-1:0]           volume;
        logic [SR_BITS-1:0]            sample_rate;
        logic [PHASE_BITS-1:0]         phase;
        logic [NOTE_BITS-1:0]          held_note;
        bit                            gate_open;
        logic signed [SAMPLE_BITS-1:0] pending_samples[$];
        int unsigned                   mismatches;
        int unsigned                   commands_seen;
        int unsigned                   samples_seen;
        int unsigned                   silent_samples;

        // note k-12 in Q4.24
        longint unsigned note_freq_q24[13] = '{
            68583572, 72661763, 76982457, 81560072, 86409886, 91548085, 96991818,
            102759251, 108869634, 115343360, 122202033, 129468544, 137167144
        };

        function new();
            pitch_offset   = PITCH_RESET;
            volume         = VOLUME_RESET;
            sample_rate    = RATE_RESET;
            phase          = '0;
            held_note      = '0;
            gate_open      = 1'b0;
            mismatches     = 0;
            commands_seen  = 0;
            samples_seen   = 0;
            silent_samples = 0;
        endfunction

        function void write_reg(logic [CFG_INDEX_BITS-1:0] index,
                                logic [CFG_DATA_BITS-1:0] data);
            case (index)
                CFG_PITCH:  pitch_offset = data[PITCH_BITS-1:0];
                CFG_VOLUME: volume = data[VOL_BITS-1:0];
                CFG_RATE:   sample_rate = data[SR_BITS-1:0];
                default:    ;
            endcase
        endfunction

        // phase increment per tick, frequency / sample rate in phase units
        function logic [PHASE_BITS-1:0] phase_step();
            longint unsigned pitch_word, semis, frac, lo, hi, base, freq;
            pitch_word = 64'(held_note);
            pitch_word = (pitch_word << 13) + 64'(pitch_offset) * 3;
            semis = pitch_word >> 13;
            frac  = pitch_word & 64'd8191;
            lo    = note_freq_q24[semis % 12];
            hi    = note_freq_q24[semis % 12 + 1];
            base  = lo + (((hi - lo) * frac) >> 13);
            freq  = (base << (semis / 12)) >> 8;
            return PHASE_BITS'((freq << (PHASE_BITS - 16)) / 64'(sample_rate));
        endfunction

        function logic signed [SAMPLE_BITS-1:0] sine_of_phase();
            logic [SINE_TABLE_BITS-1:0] idx;
            logic [1:0]                 quad;
            longint unsigned            z, z2, t, u, s, mag;
            idx  = phase[PHASE_BITS-1 -: SINE_TABLE_BITS];
            quad = idx[SINE_TABLE_BITS-1 -: 2];
            z    = 64'(idx[SINE_TABLE_BITS-3:0]);
            z    = z << (17 - SINE_TABLE_BITS);
            if (quad[0])
                z = 64'd32768 - z;
            z2 = (z * z) >> 15;
            t  = 64'd21024 - ((z2 * 64'd2320) >> 15);
            u  = 64'd51472 - ((z2 * t) >> 15);
            s  = (z * u) >> 15;
            if (s > 64'd32767)
                s = 64'd32767;
            mag = (s * 64'(volume)) >> (32 - SAMPLE_BITS);
            if (quad[1])
                return SAMPLE_BITS'(64'd0 - mag);
            return SAMPLE_BITS'(mag);
        endfunction

        function void note_command(logic [OPCODE_BITS-1:0] op, logic [NOTE_BITS-1:0] note);
            commands_seen++;
            case (op)
                OP_NOTE_ON:
                begin
                    held_note = note;
                    gate_open = 1'b1;
                end
                OP_NOTE_OFF: gate_open = 1'b0;
                OP_TICK:
                begin
                    if (sample_rate != 0)
                    begin
                        phase = phase + phase_step();
                        pending_samples.push_back(gate_open ? sine_of_phase() : '0);
                    end
                end
                default: ;
            endcase
        endfunction

        function void check_sample(logic signed [SAMPLE_BITS-1:0] actual);
            logic signed [SAMPLE_BITS-1:0] predicted;
            if (pending_samples.size() == 0)
            begin
                $error("sample: expected none, actual %0d", actual);
                mismatches++;
                return;
            end
            predicted = pending_samples.pop_front();
            samples_seen++;
            if (predicted == 0)
                silent_samples++;
            if (actual !== predicted)
            begin
                $error("sample: expected %0d, actual %0d", predicted, actual);
                mismatches++;
            end
        endfunction
    endclass

endpackage

FILE: bench/gated_sine_note_oscillator_top_test.sv
// Top-level bench for the gated sine note oscillator: stimulus, handshakes, checking and verdict.
module gated_sine_note_oscillator_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import gsno_pkg::*;
    import sine_sample_scoreboard_pkg::*;

    localparam int PHASES          = 9;
    localparam int ITEMS_PER_PHASE = 210;
    localparam int ZERO_RATE_ITEMS = 40;
    localparam int SETTLE_CYCLES   = 100;
    localparam int STALL_LIMIT     = 5000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_we;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    int unsigned               tx_idle_pct;
    int unsigned               rx_idle_pct;
    int unsigned               stall_cycles;

    sine_sample_scoreboard sb = new();

    gsno_cmd_if   cmd_ch();
    gsno_audio_if audio_ch();

    gated_sine_note_oscillator_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .audio     (audio_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
                sb.write_reg(cfg_index, cfg_data);
            if (audio_ch.valid && audio_ch.ready)
                sb.check_sample(audio_ch.sample);
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_command(cmd_ch.opcode, cmd_ch.note_number);
        end
    end

    always @(posedge clk)
        audio_ch.ready <= ($urandom_range(99) >= rx_idle_pct);

    task automatic send_command(logic [OPCODE_BITS-1:0] op, logic [NOTE_BITS-1:0] note);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid       <= 1'b1;
        cmd_ch.opcode      <= op;
        cmd_ch.note_number <= note;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic send_random_command();
        int unsigned              pick;
        logic [OPCODE_BITS-1:0]   op;
        logic [NOTE_BITS-1:0]     note;
        pick = $urandom_range(99);
        note = NOTE_BITS'($urandom);
        if (pick < 3)
            op = OP_UNUSED;
        else if (pick < 14)
            op = OP_NOTE_ON;
        else if (pick < 20)
            op = OP_NOTE_OFF;
        else
            op = OP_TICK;
        send_command(op, note);
    endtask

    task automatic write_register(logic [CFG_INDEX_BITS-1:0] index,
                                  logic [CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
    endtask

    // idle the command side, let every sample out, then let the sequencer settle
    task automatic drain();
        cmd_ch.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic configure(int phase_no);
        logic [PITCH_BITS-1:0] pitch;
        logic [VOL_BITS-1:0]   vol;
        logic [SR_BITS-1:0]    rate;
        case (phase_no)
            0:
            begin
                pitch = '0;
                vol   = '1;
                rate  = 18'd192000;
            end
            1:
            begin
                // lowest nonzero rate: increment wraps past a whole cycle
                pitch = '1;
                vol   = '1;
                rate  = 18'd1;
            end
            2:
            begin
                pitch = PITCH_RESET;
                vol   = '0;
                rate  = '0;
            end
            3:
            begin
                pitch = '1;
                vol   = 16'd1;
                rate  = '1;
            end
            default:
            begin
                pitch = PITCH_BITS'($urandom);
                vol   = VOL_BITS'($urandom);
                if ($urandom_range(3) == 0)
                    rate = SR_BITS'($urandom_range(4000, 1));
                else
                    rate = SR_BITS'($urandom_range(192000, 8000));
            end
        endcase
        write_register(CFG_PITCH, CFG_DATA_BITS'(pitch));
        write_register(CFG_VOLUME, CFG_DATA_BITS'(vol));
        write_register(CFG_RATE, rate);
        cfg_we <= 1'b0;
    endtask

    initial
    begin
        int items;
        rst_n              <= 1'b0;
        cmd_ch.valid       <= 1'b0;
        cmd_ch.opcode      <= OP_TICK;
        cmd_ch.note_number <= '0;
        cfg_we             <= 1'b0;
        cfg_index          <= CFG_PITCH;
        cfg_data           <= '0;
        tx_idle_pct        = 8;
        rx_idle_pct        = 68;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset register values
        send_command(OP_TICK, 7'd0);
        send_command(OP_UNUSED, 7'd127);
        send_command(OP_NOTE_ON, 7'd69);
        send_command(OP_TICK, 7'd127);
        send_command(OP_TICK, 7'd0);
        send_command(OP_TICK, 7'd85);
        send_command(OP_NOTE_OFF, 7'd127);
        send_command(OP_TICK, 7'd42);
        send_command(OP_NOTE_ON, 7'd0);
        send_command(OP_TICK, 7'd0);
        send_command(OP_TICK, 7'd0);
        send_command(OP_NOTE_ON, 7'd127);
        send_command(OP_TICK, 7'd0);
        send_command(OP_TICK, 7'd127);
        send_command(OP_UNUSED, 7'd0);
        send_command(OP_TICK, 7'd0);
        send_command(OP_NOTE_OFF, 7'd0);
        send_command(OP_TICK, 7'd0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p < 3)
            begin
                tx_idle_pct = 8;
                rx_idle_pct = 68;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 68;
                rx_idle_pct = 8;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            configure(p);
            items = (p == 2) ? ZERO_RATE_ITEMS : ITEMS_PER_PHASE;
            if (p == 1)
            begin
                send_command(OP_NOTE_ON, 7'd127);
                send_command(OP_TICK, 7'd0);
                send_command(OP_TICK, 7'd0);
            end
            for (int n = 0; n < items; n++)
                send_random_command();
        end
        drain();

        $display("Sent %0d commands over %0d register settings plus reset values;",
                 sb.commands_seen, PHASES);
        $display("checked %0d samples (%0d silent), incl. zero-rate and wrapping-step runs.",
                 sb.samples_seen, sb.silent_samples);
        if (sb.mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if (!rst_n || (cmd_ch.valid && cmd_ch.ready) || (audio_ch.valid && audio_ch.ready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Timeout: no transfer for %0d cycles", STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
